/* design/spmf_pkg.sv */
// shared types and constants of the strict priority multi fifo
`default_nettype none

package spmf_pkg;

  // field widths of the request and result items
  localparam int OP_W     = 1;
  localparam int PRIO_W   = 4;
  localparam int ITEM_W   = 32;
  localparam int STATUS_W = 2;

  // stream packing
  localparam int IN_PRIO_LSB  = 0;
  localparam int IN_ITEM_LSB  = IN_PRIO_LSB + PRIO_W;
  localparam int IN_TDATA_W   = ((PRIO_W + ITEM_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((ITEM_W + PRIO_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - ITEM_W - PRIO_W;

  // request operations
  localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
  localparam logic [OP_W-1:0] OP_PULL   = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // sequencer states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } spmf_state_t;

  // write strobes into the linked store
  typedef struct packed {
    logic word_we;
    logic link_we;
    logic free_we;
  } spmf_we_t;

endpackage

`default_nettype wire

/* design/spmf_store.sv */
// linked store memories: entry words, next links and the free stack
`default_nettype none

module spmf_store #(
  parameter int ENTRIES = 256,
  parameter int WORD_W  = 32
) (
  input  wire logic                       clk,
  input  wire spmf_pkg::spmf_we_t         we,
  input  wire logic [$clog2(ENTRIES)-1:0] word_raddr,
  input  wire logic [$clog2(ENTRIES)-1:0] free_raddr,
  input  wire logic [$clog2(ENTRIES)-1:0] word_waddr,
  input  wire logic [WORD_W-1:0]          word_wdata,
  input  wire logic [$clog2(ENTRIES)-1:0] link_waddr,
  input  wire logic [$clog2(ENTRIES)-1:0] link_wdata,
  input  wire logic [$clog2(ENTRIES)-1:0] free_waddr,
  input  wire logic [$clog2(ENTRIES)-1:0] free_wdata,
  output logic      [WORD_W-1:0]          word_rdata,
  output logic      [$clog2(ENTRIES)-1:0] link_rdata,
  output logic      [$clog2(ENTRIES)-1:0] free_rdata
);
  import spmf_pkg::*;

  localparam int IW = $clog2(ENTRIES);

  logic [WORD_W-1:0] word_mem [ENTRIES];
  logic [IW-1:0]     link_mem [ENTRIES];
  logic [IW-1:0]     free_mem [ENTRIES];

  // word and link share the head address on a pull
  always_ff @(posedge clk) begin
    if (we.word_we) begin
      word_mem[word_waddr] <= word_wdata;
    end
    word_rdata <= word_mem[word_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata <= link_mem[word_raddr];
  end

  // free stack of unused entry indexes
  always_ff @(posedge clk) begin
    if (we.free_we) begin
      free_mem[free_waddr] <= free_wdata;
    end
    free_rdata <= free_mem[free_raddr];
  end

endmodule

`default_nettype wire

/* design/strict_priority_multi_fifo.sv */
// Top level: strict priority queue with one fifo per level in a shared linked store.
// The result is registered in the execute state that follows the accepting idle state.
// Requests are taken only in idle, not while one executes: the store is read, then written.
// A result waiting at the output does not stop the next request; a skid stage holds one more.
// Reset: synchronous, active low; clears level flags, free count and the output stages.
// No clearing pass: free stack slots below the lowest count reached read as their own index.
`default_nettype none

module strict_priority_multi_fifo #(
  parameter int LEVELS     = 16,
  parameter int ENTRIES    = 256,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // priority_req [3:0], item_data [35:4], zero pad above
  input  wire logic [spmf_pkg::IN_TDATA_W-1:0]   in_tdata,
  // operation [0]
  input  wire logic [spmf_pkg::OP_W-1:0]         in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_data [31:0], out_priority [35:32], zero pad above
  output logic      [spmf_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // status [1:0]
  output logic      [spmf_pkg::STATUS_W-1:0]     out_tuser
);
  import spmf_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int NL = (LEVELS < (1 << PRIO_W)) ? LEVELS : (1 << PRIO_W);
  localparam int LW = $clog2(NL);
  localparam int SW = (DATA_WIDTH < ITEM_W) ? DATA_WIDTH : ITEM_W;

  spmf_state_t state_r, state_nxt;

  logic              in_fire;
  logic              exec_c;

  // request fields
  logic [PRIO_W-1:0] prio_in;
  logic [ITEM_W-1:0] item_in;
  logic [LW-1:0]     lvl_in;
  logic [LW-1:0]     top_lvl;
  logic              any_nonempty;

  // registered request
  logic [OP_W-1:0]   op_r;
  logic [LW-1:0]     lvl_r;
  logic              any_r;
  logic [IW-1:0]     head_idx_r;
  logic [SW-1:0]     word_r;

  // level state
  logic [NL-1:0]     nonempty_r, nonempty_nxt;
  logic [IW-1:0]     head_r [NL];
  logic [IW-1:0]     head_nxt [NL];
  logic [IW-1:0]     tail_r [NL];
  logic [IW-1:0]     tail_nxt [NL];
  logic [CW-1:0]     fc_r, fc_nxt;
  logic [CW-1:0]     mark_r, mark_nxt;
  logic [CW-1:0]     pos;
  logic [IW-1:0]     new_idx;

  // store ports
  spmf_we_t          st_we;
  logic [IW-1:0]     word_waddr, link_waddr, link_wdata, free_waddr, free_wdata;
  logic [SW-1:0]     word_rdata;
  logic [IW-1:0]     link_rdata, free_rdata;

  // result of the executing request
  logic [STATUS_W-1:0] res_status;
  logic [ITEM_W-1:0]   res_data;
  logic [PRIO_W-1:0]   res_prio;

  // output register and skid
  logic                out_valid_r, skid_valid_r;
  logic [STATUS_W-1:0] out_status_r, skid_status_r;
  logic [ITEM_W-1:0]   out_data_r, skid_data_r;
  logic [PRIO_W-1:0]   out_prio_r, skid_prio_r;
  logic                out_free;

  assign prio_in  = in_tdata[IN_PRIO_LSB +: PRIO_W];
  assign item_in  = in_tdata[IN_ITEM_LSB +: ITEM_W];
  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign pos      = fc_r - CW'(1);

  // clamp insert level to the levels present
  always_comb begin
    if ({1'b0, prio_in} >= (PRIO_W + 1)'(NL)) begin
      lvl_in = LW'(NL - 1);
    end else begin
      lvl_in = LW'(prio_in);
    end
  end

  // highest non-empty level
  always_comb begin
    top_lvl = '0;
    for (int k = 0; k < NL; k++) begin
      if (nonempty_r[k]) begin
        top_lvl = LW'(k);
      end
    end
  end
  assign any_nonempty = |nonempty_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    exec_c    = 1'b0;
    unique case (state_r)
      S_IDLE:  in_tready = !skid_valid_r;
      S_EXEC:  exec_c    = 1'b1;
      default: begin
        in_tready = 1'b0;
        exec_c    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // capture the request and its level
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r       <= in_tuser;
      lvl_r      <= (in_tuser == OP_PULL) ? top_lvl : lvl_in;
      any_r      <= any_nonempty;
      head_idx_r <= head_r[top_lvl];
      word_r     <= item_in[SW-1:0];
    end
  end

  // modify step: allocate or release an entry and relink the level
  always_comb begin
    st_we        = '0;
    word_waddr   = '0;
    link_waddr   = '0;
    link_wdata   = '0;
    free_waddr   = '0;
    free_wdata   = '0;
    new_idx      = '0;
    nonempty_nxt = nonempty_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    fc_nxt       = fc_r;
    mark_nxt     = mark_r;
    res_status   = ST_OK;
    res_data     = '0;
    res_prio     = '0;
    if (exec_c) begin
      if (op_r == OP_INSERT) begin
        if (fc_r == '0) begin
          res_status = ST_FULL;
        end else begin
          new_idx           = (pos < mark_r) ? pos[IW-1:0] : free_rdata;
          st_we.word_we     = 1'b1;
          word_waddr        = new_idx;
          if (nonempty_r[lvl_r]) begin
            st_we.link_we = 1'b1;
            link_waddr    = tail_r[lvl_r];
            link_wdata    = new_idx;
          end else begin
            head_nxt[lvl_r] = new_idx;
          end
          tail_nxt[lvl_r]     = new_idx;
          nonempty_nxt[lvl_r] = 1'b1;
          fc_nxt              = pos;
          if (pos < mark_r) mark_nxt = pos;
        end
      end else begin
        if (!any_r) begin
          res_status = ST_EMPTY;
        end else begin
          res_data = ITEM_W'(word_rdata);
          res_prio = PRIO_W'(lvl_r);
          if (head_idx_r == tail_r[lvl_r]) begin
            nonempty_nxt[lvl_r] = 1'b0;
          end else begin
            head_nxt[lvl_r] = link_rdata;
          end
          st_we.free_we = 1'b1;
          free_waddr    = fc_r[IW-1:0];
          free_wdata    = head_idx_r;
          fc_nxt        = fc_r + CW'(1);
        end
      end
    end
  end

  // level flags and free count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r <= '0;
      fc_r       <= CW'(ENTRIES);
      mark_r     <= CW'(ENTRIES);
    end else begin
      nonempty_r <= nonempty_nxt;
      fc_r       <= fc_nxt;
      mark_r     <= mark_nxt;
    end
  end

  // head and tail pointers, read only while their level is non-empty
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  spmf_store #(
    .ENTRIES (ENTRIES),
    .WORD_W  (SW)
  ) u_store (
    .clk        (clk),
    .we         (st_we),
    .word_raddr (head_r[top_lvl]),
    .free_raddr (pos[IW-1:0]),
    .word_waddr (word_waddr),
    .word_wdata (word_r),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .free_waddr (free_waddr),
    .free_wdata (free_wdata),
    .word_rdata (word_rdata),
    .link_rdata (link_rdata),
    .free_rdata (free_rdata)
  );

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (exec_c) begin
      if (out_free) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r && out_free) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_c) begin
      if (out_free) begin
        out_status_r <= res_status;
        out_data_r   <= res_data;
        out_prio_r   <= res_prio;
      end else begin
        skid_status_r <= res_status;
        skid_data_r   <= res_data;
        skid_prio_r   <= res_prio;
      end
    end else if (skid_valid_r && out_free) begin
      out_status_r <= skid_status_r;
      out_data_r   <= skid_data_r;
      out_prio_r   <= skid_prio_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_prio_r, out_data_r};

  // checks
  a_fc_range: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= CW'(ENTRIES))
    else $error("free count beyond store size");

  a_mark_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    mark_r <= fc_r)
    else $error("free stack mark above free count");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while output is empty");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC) && !skid_valid_r)
    else $error("accepted request not executed next cycle");

endmodule

`default_nettype wire
